// ----- design/rsdm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsdm_pkg
// Shared types and constants for the reference switch debounce monitor.
// ----------------------------------------------------------------------------
package rsdm_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int MS_W           = 32;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int FAULT_W        = 3;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_READY         = 3'd0,
        FAULT_NOT_INSTALLED = 3'd1,
        FAULT_DISCONNECTED  = 3'd2,
        FAULT_STALE         = 3'd3,
        FAULT_UNREFERENCED  = 3'd4
    } fault_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED         = 3'd0,
        REG_ACTIVE_LOW      = 3'd1,
        REG_ROUTINE_ALLOWED = 3'd2,
        REG_DEBOUNCE_MS     = 3'd3,
        REG_STALE_MS        = 3'd4
    } cfg_reg_t;

    localparam logic KIND_SAMPLE = 1'b0;

    localparam logic             ENABLED_RST         = 1'b1;
    localparam logic             ACTIVE_LOW_RST      = 1'b0;
    localparam logic             ROUTINE_ALLOWED_RST = 1'b0;
    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST     = 16'd20;
    localparam logic [CFG_W-1:0] STALE_MS_RST        = 16'd500;

endpackage : rsdm_pkg
`default_nettype wire

// ----- design/reference_switch_debounce_monitor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// reference_switch_debounce_monitor
// Debounces a reference switch pin, latches the referenced flag and reports
// sample age, freshness and a prioritized fault for every word.
// ----------------------------------------------------------------------------
// Every input word (pin sample or status query) yields one status word. A word
// is registered on acceptance; the state update and status are computed
// combinationally from the input register and land in the output register
// when it advances, which a result waiting downstream can hold off. One word
// per cycle is sustained while the output is not stalled: the single update
// stage between the input and output registers carries the whole per-word
// work. While a result waits downstream the input register takes one more
// word and then the input stalls until the result is taken.
// Configuration writes take effect on the next processed word.
module reference_switch_debounce_monitor #(
    parameter int TIME_WIDTH = rsdm_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wen,
    input  wire logic [rsdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rsdm_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [rsdm_pkg::MS_W-1:0]      s_now_ms,
    input  wire logic                          s_raw_level,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [rsdm_pkg::FAULT_W-1:0]        m_fault_code,
    output logic                               m_connected,
    output logic                               m_fresh,
    output logic                               m_referenced,
    output logic                               m_hardware_ready,
    output logic                               m_ready_for_routine,
    output logic                               m_signal_active,
    output logic [rsdm_pkg::MS_W-1:0]           m_age_ms,
    output logic [rsdm_pkg::MS_W-1:0]           m_last_update_ms
);
    import rsdm_pkg::*;

    // configuration
    logic             enabled_reg;
    logic             active_low_reg;
    logic             routine_allowed_reg;
    logic [CFG_W-1:0] debounce_ms_reg;
    logic [CFG_W-1:0] stale_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg         <= ENABLED_RST;
            active_low_reg      <= ACTIVE_LOW_RST;
            routine_allowed_reg <= ROUTINE_ALLOWED_RST;
            debounce_ms_reg     <= DEBOUNCE_MS_RST;
            stale_ms_reg        <= STALE_MS_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_ENABLED:         enabled_reg         <= cfg_wdata[0];
                REG_ACTIVE_LOW:      active_low_reg      <= cfg_wdata[0];
                REG_ROUTINE_ALLOWED: routine_allowed_reg <= cfg_wdata[0];
                REG_DEBOUNCE_MS:     debounce_ms_reg     <= cfg_wdata;
                REG_STALE_MS:        stale_ms_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    logic            in_valid_reg;
    logic            in_kind_reg;
    logic [MS_W-1:0] in_now_reg;
    logic            in_level_reg;
    logic            advance;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg  <= s_kind;
            in_now_reg   <= s_now_ms;
            in_level_reg <= s_raw_level;
        end
    end

    // switch state
    logic                  init_reg, init_next;
    logic                  raw_reg, raw_next;
    logic                  stable_reg, stable_next;
    logic                  ref_reg, ref_next;
    logic [TIME_WIDTH-1:0] changed_at_reg, changed_at_next;
    logic [TIME_WIDTH-1:0] last_at_reg, last_at_next;

    logic [TIME_WIDTH+MS_W-1:0]  now_wide;
    logic [TIME_WIDTH+CFG_W-1:0] db_wide;
    logic [TIME_WIDTH+CFG_W-1:0] stale_wide;
    logic [TIME_WIDTH-1:0]       now_t;
    logic [TIME_WIDTH-1:0]       db_t;
    logic [TIME_WIDTH-1:0]       stale_t;
    logic [TIME_WIDTH-1:0]       held_t;
    logic [TIME_WIDTH-1:0]       age_t;
    logic [TIME_WIDTH+MS_W-1:0]  age_wide;
    logic [TIME_WIDTH+MS_W-1:0]  last_wide;
    logic                        active;
    logic                        take;

    assign now_wide   = {{TIME_WIDTH{1'b0}}, in_now_reg};
    assign now_t      = now_wide[TIME_WIDTH-1:0];
    assign db_wide    = {{TIME_WIDTH{1'b0}}, debounce_ms_reg};
    assign db_t       = db_wide[TIME_WIDTH-1:0];
    assign stale_wide = {{TIME_WIDTH{1'b0}}, stale_ms_reg};
    assign stale_t    = stale_wide[TIME_WIDTH-1:0];
    assign active     = in_level_reg ^ active_low_reg;
    assign take       = advance && enabled_reg && (in_kind_reg == KIND_SAMPLE);

    always_comb begin
        init_next       = init_reg;
        raw_next        = raw_reg;
        stable_next     = stable_reg;
        ref_next        = ref_reg;
        changed_at_next = changed_at_reg;
        last_at_next    = last_at_reg;
        held_t          = now_t - changed_at_reg;
        if (take) begin
            if (!init_reg) begin
                init_next       = 1'b1;
                raw_next        = active;
                stable_next     = active;
                ref_next        = active;
                changed_at_next = now_t;
            end else begin
                if (active != raw_reg) begin
                    raw_next        = active;
                    changed_at_next = now_t;
                end
                held_t = now_t - changed_at_next;
                if ((active != stable_reg) && (held_t >= db_t)) begin
                    stable_next = active;
                    if (active) begin
                        ref_next = 1'b1;
                    end
                end
            end
            last_at_next = now_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg       <= 1'b0;
            raw_reg        <= 1'b0;
            stable_reg     <= 1'b0;
            ref_reg        <= 1'b0;
            changed_at_reg <= '0;
            last_at_reg    <= '0;
        end else begin
            init_reg       <= init_next;
            raw_reg        <= raw_next;
            stable_reg     <= stable_next;
            ref_reg        <= ref_next;
            changed_at_reg <= changed_at_next;
            last_at_reg    <= last_at_next;
        end
    end

    // status
    logic            st_fresh;
    logic            st_hw_ready;
    fault_t          st_fault;
    logic [MS_W-1:0] st_age;
    logic [MS_W-1:0] st_last;

    assign age_t     = now_t - last_at_next;
    assign age_wide  = {{MS_W{1'b0}}, age_t};
    assign last_wide = {{MS_W{1'b0}}, last_at_next};

    always_comb begin
        st_age      = init_next ? age_wide[MS_W-1:0]  : '0;
        st_last     = init_next ? last_wide[MS_W-1:0] : '0;
        st_fresh    = init_next && (age_t <= stale_t);
        st_hw_ready = st_fresh && ref_next;
        if (!init_next) begin
            st_fault = FAULT_DISCONNECTED;
        end else if (!st_fresh) begin
            st_fault = FAULT_STALE;
        end else if (!ref_next) begin
            st_fault = FAULT_UNREFERENCED;
        end else begin
            st_fault = FAULT_READY;
        end
    end

    // output register
    logic              m_valid_reg;
    fault_t            fault_reg;
    logic              connected_reg;
    logic              fresh_reg;
    logic              referenced_reg;
    logic              hw_ready_reg;
    logic              routine_reg;
    logic              signal_reg;
    logic [MS_W-1:0]   age_reg;
    logic [MS_W-1:0]   last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (!enabled_reg) begin
                fault_reg      <= FAULT_NOT_INSTALLED;
                connected_reg  <= 1'b0;
                fresh_reg      <= 1'b0;
                referenced_reg <= 1'b0;
                hw_ready_reg   <= 1'b0;
                routine_reg    <= 1'b0;
                signal_reg     <= 1'b0;
                age_reg        <= '0;
                last_reg       <= '0;
            end else begin
                fault_reg      <= st_fault;
                connected_reg  <= init_next;
                fresh_reg      <= st_fresh;
                referenced_reg <= ref_next;
                hw_ready_reg   <= st_hw_ready;
                routine_reg    <= st_hw_ready && routine_allowed_reg;
                signal_reg     <= init_next && stable_next;
                age_reg        <= st_age;
                last_reg       <= st_last;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_fault_code        = fault_reg;
    assign m_connected         = connected_reg;
    assign m_fresh             = fresh_reg;
    assign m_referenced        = referenced_reg;
    assign m_hardware_ready    = hw_ready_reg;
    assign m_ready_for_routine = routine_reg;
    assign m_signal_active     = signal_reg;
    assign m_age_ms            = age_reg;
    assign m_last_update_ms    = last_reg;

    // checks
    a_routine_needs_hw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_ready_for_routine || m_hardware_ready))
        else $error("ready_for_routine without hardware_ready");

    a_ready_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_fault_code == FAULT_READY) == m_hardware_ready))
        else $error("fault code disagrees with hardware_ready");

    a_disconnected_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_connected) |-> (m_age_ms == '0 && m_last_update_ms == '0
                                       && !m_signal_active && !m_fresh))
        else $error("disconnected status carries sample data");

    a_ref_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(ref_reg) |-> ref_reg)
        else $error("referenced flag cleared without reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_age_ms)
                                   && $stable(m_fault_code)))
        else $error("stalled status word changed");

endmodule : reference_switch_debounce_monitor
`default_nettype wire
